// ===== rtl/tss_pkg.sv =====
// Shared types and codes for the TCP session state tracker.
package tss_pkg;

  // Session state codes as seen on the result beat.
  localparam logic [2:0] CODE_INIT        = 3'd0;
  localparam logic [2:0] CODE_HANDSHAKE   = 3'd1;
  localparam logic [2:0] CODE_CLIENT_SEND = 3'd2;
  localparam logic [2:0] CODE_SERVER_SEND = 3'd3;
  localparam logic [2:0] CODE_CLIENT_FIN  = 3'd4;
  localparam logic [2:0] CODE_SERVER_FIN  = 3'd5;
  localparam logic [2:0] CODE_CLOSED      = 3'd6;

  // Packet direction.
  localparam logic DIR_TO_SERVER = 1'b0;
  localparam logic DIR_TO_CLIENT = 1'b1;

  typedef struct packed {
    logic        syn_flag;
    logic        ack_flag;
    logic        rst_flag;
    logic        fin_flag;
    logic        direction;
    logic [31:0] seq_number;
    logic [15:0] payload_length;
  } tss_in_t;

  typedef struct packed {
    logic [2:0]  session_state_out;
    logic        first_payload_event;
    logic        direction_reversed_event;
    logic        payload_event;
    logic        fin_event;
    logic        rst_event;
    logic [31:0] write_offset;
    logic [31:0] window_length;
  } tss_out_t;

  // Classified packet, as queued between front and back.
  // sum holds seq+len for payload packets and seq+1 for SYN packets.
  typedef struct packed {
    logic        syn;
    logic        syn_ack;
    logic        pay;
    logic        rst;
    logic        fin;
    logic        dir;
    logic [31:0] seq;
    logic [32:0] sum;
  } tss_op_t;

endpackage

// ===== rtl/tss_front.sv =====
// Front end: accepts header beats and classifies them into queued operations.
module tss_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  tss_pkg::tss_in_t in_beat,
  input  logic             q_full,
  output logic             q_push,
  output tss_pkg::tss_op_t q_op
);
  import tss_pkg::*;

  logic [15:0] addend;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // SYN overrides everything else; SYN reuses the adder for seq+1.
  assign addend = in_beat.syn_flag ? 16'd1 : in_beat.payload_length;

  always_comb begin
    q_op.syn     = in_beat.syn_flag;
    q_op.syn_ack = in_beat.syn_flag && in_beat.ack_flag;
    q_op.pay     = !in_beat.syn_flag && (in_beat.payload_length != 16'd0);
    q_op.rst     = !in_beat.syn_flag && in_beat.rst_flag;
    q_op.fin     = !in_beat.syn_flag && !in_beat.rst_flag && in_beat.fin_flag;
    q_op.dir     = in_beat.direction;
    q_op.seq     = in_beat.seq_number;
    q_op.sum     = {1'b0, in_beat.seq_number} + {17'd0, addend};
  end

endmodule

// ===== rtl/tss_queue.sv =====
// Small FIFO of classified operations between front and back.
module tss_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tss_pkg::tss_op_t push_op,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output tss_pkg::tss_op_t head_op
);
  import tss_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tss_op_t            slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_op   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== rtl/tss_back.sv =====
// Back end: session state, per-direction windows and the result register.
module tss_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  tss_pkg::tss_op_t  q_op,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output tss_pkg::tss_out_t out_beat
);
  import tss_pkg::*;

  typedef enum logic [5:0] {
    ST_HANDSHAKE   = 6'b000001,
    ST_CLIENT_SEND = 6'b000010,
    ST_SERVER_SEND = 6'b000100,
    ST_CLIENT_FIN  = 6'b001000,
    ST_SERVER_FIN  = 6'b010000,
    ST_CLOSED      = 6'b100000
  } sess_state_t;

  sess_state_t state_r, state_nxt, state_mid;
  logic [31:0] start_r [2];
  logic [31:0] end_r   [2];
  logic        out_valid_r;
  tss_out_t    out_beat_r, out_beat_nxt;

  logic [31:0] start_cur, end_cur, start_new, end_new;
  logic        first_ev, rev_ev;
  logic [2:0]  state_code;

  // Take a new op whenever the result register is free or draining.
  assign q_pop = q_not_empty && (!out_valid_r || !out_stall);

  assign start_cur = start_r[q_op.dir];
  assign end_cur   = end_r[q_op.dir];

  always_comb begin
    if (q_op.syn) begin
      start_new = (q_op.syn_ack && (q_op.dir == DIR_TO_CLIENT)) ? q_op.sum[31:0] : start_cur;
      end_new   = end_cur;
    end else if (q_op.pay) begin
      start_new = (start_cur == 32'd0) ? q_op.seq : start_cur;
      end_new   = (q_op.sum > {1'b0, end_cur}) ? q_op.sum[31:0] : end_cur;
    end else begin
      start_new = start_cur;
      end_new   = end_cur;
    end
  end

  // Payload transition first, then SYN, RST or FIN on top of it.
  always_comb begin
    first_ev  = 1'b0;
    rev_ev    = 1'b0;
    state_mid = state_r;
    if (q_op.pay) begin
      unique case (state_r)
        ST_HANDSHAKE: begin
          first_ev  = 1'b1;
          state_mid = (q_op.dir == DIR_TO_SERVER) ? ST_CLIENT_SEND : ST_SERVER_SEND;
        end
        ST_CLIENT_SEND: begin
          if (q_op.dir != DIR_TO_SERVER) begin
            rev_ev    = 1'b1;
            state_mid = ST_SERVER_SEND;
          end
        end
        ST_SERVER_SEND: begin
          if (q_op.dir == DIR_TO_SERVER) begin
            rev_ev    = 1'b1;
            state_mid = ST_CLIENT_SEND;
          end
        end
        ST_SERVER_FIN: begin
          if (q_op.dir != DIR_TO_SERVER) state_mid = ST_CLOSED;
        end
        ST_CLIENT_FIN: begin
          if (q_op.dir == DIR_TO_SERVER) state_mid = ST_CLOSED;
        end
        default: state_mid = state_r;
      endcase
    end

    state_nxt = state_mid;
    if (q_op.syn) begin
      state_nxt = ST_HANDSHAKE;
    end else if (q_op.rst) begin
      state_nxt = ST_CLOSED;
    end else if (q_op.fin) begin
      unique case (state_mid) inside
        ST_HANDSHAKE, ST_CLIENT_SEND, ST_SERVER_SEND: begin
          state_nxt = (q_op.dir == DIR_TO_CLIENT) ? ST_SERVER_FIN : ST_CLIENT_FIN;
        end
        ST_SERVER_FIN: begin
          if (q_op.dir != DIR_TO_CLIENT) state_nxt = ST_CLOSED;
        end
        ST_CLIENT_FIN: begin
          if (q_op.dir == DIR_TO_CLIENT) state_nxt = ST_CLOSED;
        end
        default: state_nxt = state_mid;
      endcase
    end
  end

  always_comb begin
    unique case (state_nxt)
      ST_HANDSHAKE:   state_code = CODE_HANDSHAKE;
      ST_CLIENT_SEND: state_code = CODE_CLIENT_SEND;
      ST_SERVER_SEND: state_code = CODE_SERVER_SEND;
      ST_CLIENT_FIN:  state_code = CODE_CLIENT_FIN;
      ST_SERVER_FIN:  state_code = CODE_SERVER_FIN;
      ST_CLOSED:      state_code = CODE_CLOSED;
      default:        state_code = CODE_INIT;
    endcase
  end

  always_comb begin
    out_beat_nxt.session_state_out        = state_code;
    out_beat_nxt.first_payload_event      = first_ev;
    out_beat_nxt.direction_reversed_event = rev_ev;
    out_beat_nxt.payload_event            = q_op.pay;
    out_beat_nxt.fin_event                = q_op.fin;
    out_beat_nxt.rst_event                = q_op.rst;
    out_beat_nxt.write_offset             = q_op.pay ? (q_op.seq - start_new) : 32'd0;
    out_beat_nxt.window_length            = end_new - start_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HANDSHAKE;
      start_r[0]  <= '0;
      start_r[1]  <= '0;
      end_r[0]    <= '0;
      end_r[1]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
        if (q_op.syn) begin
          if (q_op.syn_ack) start_r[DIR_TO_CLIENT] <= q_op.sum[31:0];
        end else begin
          start_r[q_op.dir] <= start_new;
          end_r[q_op.dir]   <= end_new;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// ===== rtl/tcp_session_state_tracker.sv =====
// Top level of the TCP session state tracker: front, queue and back.
//
// Takes one TCP header beat per cycle while in_stall is low (flags,
// direction, sequence number, payload length) and returns exactly one result
// beat for it, in order: the session state after the packet, the
// first-payload, direction-reversal, payload, FIN and RST events, the
// payload's offset into its direction's reassembly window and that window's
// length. Sustained rate is one beat per clock while out_stall is low; the
// limit is the back end's loop that reads and writes the session state and
// the window start/end of the packet's direction. The front classifies
// combinationally and writes the queue at the accepting edge; the back then
// pops the entry, updates state and loads the result register, which drives
// out_valid. The queue of QUEUE_DEPTH entries lets the input keep flowing
// while the result side is stalled; in_stall rises only once the queue is
// full. After reset the session is in the handshake state and both windows
// are zero; a window start of zero means not yet set.
module tcp_session_state_tracker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tss_pkg::tss_in_t  in_beat,
  output logic              out_valid,
  input  logic              out_stall,
  output tss_pkg::tss_out_t out_beat
);
  import tss_pkg::*;

  tss_op_t push_op, head_op;
  logic    q_push, q_pop, q_full, q_not_empty;

  // Classify the header and push it while the queue has room.
  tss_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (push_op)
  );

  // Decouple acceptance from result backpressure.
  tss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (push_op),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_op   (head_op)
  );

  // Advance the session and windows, and hold the result until taken.
  tss_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_op        (head_op),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_beat    (out_beat)
  );

endmodule

// ===== test/tb_tcp_session_state_tracker.sv =====
// Self-checking testbench for the TCP session state tracker.
`timescale 1ns / 1ps

module tb_tcp_session_state_tracker;
  import tss_pkg::*;

  localparam int RANDOM_HEADERS = 700;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLD_CYCLES    = 60;
  localparam int HOLD_SPACING   = 180;
  localparam int PRINT_CAP      = 30;

  // Quiet handshake-state result: no events, no offset, empty window.
  localparam tss_out_t HS_QUIET = '{CODE_HANDSHAKE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                    32'h0, 32'h0};
  localparam tss_out_t UNTYPED  = '0;

  // One row of the directed table: the header, and the result where it is
  // obvious enough to write down by hand.
  typedef struct packed {
    tss_in_t  pkt;
    logic     typed;
    tss_out_t want;
  } dir_row_t;

  localparam int N_ROWS = 26;
  localparam dir_row_t DIRECTED_ROWS [N_ROWS] = '{
    // bare ACK right after reset
    '{'{1'b0, 1'b1, 1'b0, 1'b0, DIR_TO_SERVER, 32'h0000_0000, 16'h0000}, 1'b1, HS_QUIET},
    // plain SYN
    '{'{1'b1, 1'b0, 1'b0, 1'b0, DIR_TO_SERVER, 32'h0000_0064, 16'h0000}, 1'b1, HS_QUIET},
    // SYN+ACK at the top of the sequence space: seq+1 wraps to zero
    '{'{1'b1, 1'b1, 1'b0, 1'b0, DIR_TO_CLIENT, 32'hFFFF_FFFF, 16'h0000}, 1'b1, HS_QUIET},
    '{'{1'b1, 1'b1, 1'b0, 1'b0, DIR_TO_CLIENT, 32'h0000_03E8, 16'h0000}, 1'b0, UNTYPED},
    // SYN carrying RST, FIN and payload: everything but the SYN is dropped
    '{'{1'b1, 1'b0, 1'b1, 1'b1, DIR_TO_SERVER, 32'h0000_0005, 16'h000A}, 1'b1, HS_QUIET},
    // first payload loads the unset window start
    '{'{1'b0, 1'b1, 1'b0, 1'b0, DIR_TO_SERVER, 32'h0000_1000, 16'h0100}, 1'b1,
      '{CODE_CLIENT_SEND, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0000_0100}},
    '{'{1'b0, 1'b1, 1'b0, 1'b0, DIR_TO_SERVER, 32'h0000_1100, 16'hFFFF}, 1'b0, UNTYPED},
    // reversal toward the client, then back with no window growth
    '{'{1'b0, 1'b1, 1'b0, 1'b0, DIR_TO_CLIENT, 32'h0000_07D0, 16'h0001}, 1'b0, UNTYPED},
    '{'{1'b0, 1'b0, 1'b0, 1'b0, DIR_TO_SERVER, 32'h0000_1050, 16'h0001}, 1'b0, UNTYPED},
    // end sum past 2^32: grows, stored wrapped
    '{'{1'b0, 1'b1, 1'b0, 1'b0, DIR_TO_SERVER, 32'hFFFF_FFFF, 16'hFFFF}, 1'b0, UNTYPED},
    // client finishes; other side may still send, same side finishing again holds
    '{'{1'b0, 1'b1, 1'b0, 1'b1, DIR_TO_SERVER, 32'h0000_0000, 16'h0000}, 1'b0, UNTYPED},
    '{'{1'b0, 1'b1, 1'b0, 1'b0, DIR_TO_CLIENT, 32'h0000_0800, 16'h0020}, 1'b0, UNTYPED},
    '{'{1'b0, 1'b1, 1'b0, 1'b1, DIR_TO_SERVER, 32'h0000_0000, 16'h0000}, 1'b0, UNTYPED},
    // payload from the finished client closes
    '{'{1'b0, 1'b1, 1'b0, 1'b0, DIR_TO_SERVER, 32'h0000_2000, 16'h0010}, 1'b0, UNTYPED},
    // payload plus FIN once closed: state holds
    '{'{1'b0, 1'b1, 1'b0, 1'b1, DIR_TO_CLIENT, 32'h0000_0900, 16'h0008}, 1'b0, UNTYPED},
    '{'{1'b0, 1'b1, 1'b1, 1'b0, DIR_TO_CLIENT, 32'h0000_0A00, 16'h0004}, 1'b0, UNTYPED},
    // server-side finish path
    '{'{1'b1, 1'b0, 1'b0, 1'b0, DIR_TO_SERVER, 32'h0000_0000, 16'h0000}, 1'b0, UNTYPED},
    '{'{1'b0, 1'b1, 1'b0, 1'b1, DIR_TO_CLIENT, 32'h0000_0000, 16'h0000}, 1'b0, UNTYPED},
    '{'{1'b0, 1'b1, 1'b0, 1'b1, DIR_TO_CLIENT, 32'h0000_0000, 16'h0000}, 1'b0, UNTYPED},
    '{'{1'b0, 1'b1, 1'b0, 1'b1, DIR_TO_SERVER, 32'h0000_0000, 16'h0000}, 1'b0, UNTYPED},
    // RST wins over FIN in the same header
    '{'{1'b1, 1'b0, 1'b0, 1'b0, DIR_TO_CLIENT, 32'h0000_0000, 16'h0000}, 1'b0, UNTYPED},
    '{'{1'b0, 1'b1, 1'b1, 1'b1, DIR_TO_SERVER, 32'h0000_0000, 16'h0000}, 1'b0, UNTYPED},
    // payload and FIN together from handshake, then the client and the finished server send
    '{'{1'b1, 1'b0, 1'b0, 1'b0, DIR_TO_SERVER, 32'h0000_0000, 16'h0000}, 1'b0, UNTYPED},
    '{'{1'b0, 1'b1, 1'b0, 1'b1, DIR_TO_CLIENT, 32'h0000_0B00, 16'h0040}, 1'b0, UNTYPED},
    '{'{1'b0, 1'b1, 1'b0, 1'b0, DIR_TO_SERVER, 32'h0000_3000, 16'h0001}, 1'b0, UNTYPED},
    '{'{1'b0, 1'b1, 1'b0, 1'b0, DIR_TO_CLIENT, 32'h0000_0C00, 16'h0001}, 1'b0, UNTYPED}
  };

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  tss_in_t  in_beat   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tss_out_t out_beat;

  // Tracker copy of the session: state code and per-direction window bounds.
  logic [2:0]  trk_state;
  logic [31:0] win_start [2];
  logic [31:0] win_end   [2];

  tss_out_t results_due [$];
  tss_out_t want_now;

  int mismatches     = 0;
  int headers_sent   = 0;
  int results_seen   = 0;
  int sessions_run   = 0;
  int noise_headers  = 0;
  int burst_left     = 0;
  int hold_asks      = 0;
  int hold_taken     = 0;
  int hold_left      = 0;
  int rx_seg_left    = 0;
  int next_hold_mark = 0;
  rx_mode_t rx_mode  = RX_FREE;

  tcp_session_state_tracker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Session tracker: advance the local copy by one header and return the
  // result beat the block must produce for it.
  // ---------------------------------------------------------------------
  function automatic tss_out_t track_header(input tss_in_t p);
    tss_out_t    r;
    logic [32:0] reach;
    logic        d;
    r = '0;
    d = p.direction;
    if (p.syn_flag) begin
      // SYN re-enters handshake and, with ACK, loads the client window start; the rest is dropped
      trk_state = CODE_HANDSHAKE;
      if (p.ack_flag) win_start[DIR_TO_CLIENT] = p.seq_number + 32'd1;
    end else begin
      if (p.payload_length != 16'd0) begin
        reach = {1'b0, p.seq_number} + {17'd0, p.payload_length};
        // a zero start means the window has not been opened yet
        if (win_start[d] == 32'd0) win_start[d] = p.seq_number;
        // compare unwrapped, store wrapped
        if (reach > {1'b0, win_end[d]}) win_end[d] = reach[31:0];
        r.write_offset  = p.seq_number - win_start[d];
        r.payload_event = 1'b1;
        case (trk_state) inside
          CODE_INIT, CODE_HANDSHAKE: begin
            r.first_payload_event = 1'b1;
            trk_state = (d == DIR_TO_SERVER) ? CODE_CLIENT_SEND : CODE_SERVER_SEND;
          end
          CODE_CLIENT_SEND: begin
            if (d != DIR_TO_SERVER) begin
              r.direction_reversed_event = 1'b1;
              trk_state = CODE_SERVER_SEND;
            end
          end
          CODE_SERVER_SEND: begin
            if (d == DIR_TO_SERVER) begin
              r.direction_reversed_event = 1'b1;
              trk_state = CODE_CLIENT_SEND;
            end
          end
          // payload from a side that already finished closes the session
          CODE_SERVER_FIN: if (d != DIR_TO_SERVER) trk_state = CODE_CLOSED;
          CODE_CLIENT_FIN: if (d == DIR_TO_SERVER) trk_state = CODE_CLOSED;
          default: ;
        endcase
      end
      if (p.rst_flag) begin
        r.rst_event = 1'b1;
        trk_state = CODE_CLOSED;
      end else if (p.fin_flag) begin
        r.fin_event = 1'b1;
        case (trk_state) inside
          CODE_INIT, CODE_HANDSHAKE, CODE_CLIENT_SEND, CODE_SERVER_SEND:
            trk_state = (d == DIR_TO_CLIENT) ? CODE_SERVER_FIN : CODE_CLIENT_FIN;
          CODE_SERVER_FIN: if (d != DIR_TO_CLIENT) trk_state = CODE_CLOSED;
          CODE_CLIENT_FIN: if (d == DIR_TO_CLIENT) trk_state = CODE_CLOSED;
          default: ;
        endcase
      end
    end
    r.session_state_out = trk_state;
    r.window_length     = win_end[d] - win_start[d];
    return r;
  endfunction

  function automatic tss_in_t hdr(input logic syn, input logic ack, input logic rst,
                                  input logic fin, input logic dir,
                                  input logic [31:0] seq, input logic [15:0] len);
    tss_in_t h;
    h = '{syn, ack, rst, fin, dir, seq, len};
    return h;
  endfunction

  // Random single bit for header flags and direction.
  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Mostly MSS-sized payloads, with some empty, some maximal, some anywhere.
  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 16'hFFFF;
    if (r == 1) return 16'($urandom_range(0, 65535));
    if (r == 2) return 16'd0;
    return 16'($urandom_range(1, 1460));
  endfunction

  // ---------------------------------------------------------------------
  // Sender. Entered and left on a falling edge. Hold the beat until it is
  // taken, then queue what the tracker says must come back.
  // ---------------------------------------------------------------------
  task automatic offer_header(input tss_in_t b, input logic typed, input tss_out_t want);
    tss_out_t pred;
    if (burst_left <= 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    in_valid = 1'b1;
    in_beat  = b;
    do @(posedge clk); while (in_stall);
    pred = track_header(b);
    results_due.push_back(typed ? want : pred);
    headers_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send(input tss_in_t b);
    offer_header(b, 1'b0, UNTYPED);
  endtask

  // Drop valid and wait for every outstanding result to come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  // One connection: handshake, a data phase, then a close of some kind.
  // A broken session skips parts of the handshake and may stop mid-data.
  task automatic play_session(input logic broken);
    logic [31:0] cli_seq;
    logic [31:0] srv_seq;
    logic [31:0] seq;
    logic [15:0] len;
    logic        d;
    int          n_data;
    int          cut;
    cli_seq = $urandom;
    srv_seq = $urandom;
    cut     = broken ? $urandom_range(0, 6) : 1000;
    sessions_run++;
    if (!broken || coin())
      send(hdr(1'b1, 1'b0, 1'b0, 1'b0, DIR_TO_SERVER, cli_seq, 16'd0));
    cli_seq++;
    if (!broken || coin())
      send(hdr(1'b1, 1'b1, 1'b0, 1'b0, DIR_TO_CLIENT, srv_seq, 16'd0));
    srv_seq++;
    send(hdr(1'b0, 1'b1, 1'b0, 1'b0, DIR_TO_SERVER, cli_seq, 16'd0));
    n_data = $urandom_range(2, 16);
    d = DIR_TO_SERVER;
    for (int k = 0; k < n_data; k++) begin
      if (k >= cut) return;
      if ($urandom_range(0, 3) == 0) d = ~d;
      len = pick_len();
      seq = (d == DIR_TO_SERVER) ? cli_seq : srv_seq;
      // occasional retransmission or overlap
      if ($urandom_range(0, 9) == 0) seq = seq - 32'($urandom_range(1, 3000));
      send(hdr(1'b0, 1'b1, 1'b0, 1'b0, d, seq, len));
      if (d == DIR_TO_SERVER) cli_seq = seq + len;
      else srv_seq = seq + len;
    end
    case ($urandom_range(0, 4))
      0: begin
        send(hdr(1'b0, 1'b1, 1'b0, 1'b1, DIR_TO_SERVER, cli_seq, 16'd0));
        send(hdr(1'b0, 1'b1, 1'b0, 1'b1, DIR_TO_CLIENT, srv_seq, 16'd0));
      end
      1: begin
        // server finishes, client keeps sending, then the client finishes
        send(hdr(1'b0, 1'b1, 1'b0, 1'b1, DIR_TO_CLIENT, srv_seq, pick_len()));
        send(hdr(1'b0, 1'b1, 1'b0, 1'b0, DIR_TO_SERVER, cli_seq, pick_len()));
        send(hdr(1'b0, 1'b1, 1'b0, 1'b1, DIR_TO_SERVER, cli_seq, 16'd0));
      end
      2: send(hdr(1'b0, coin(), 1'b1, coin(), d, $urandom, pick_len()));
      3: begin
        // FIN with data, then the finished side sends again
        send(hdr(1'b0, 1'b1, 1'b0, 1'b1, d, d ? srv_seq : cli_seq, pick_len()));
        send(hdr(1'b0, 1'b1, 1'b0, 1'b0, d, d ? srv_seq : cli_seq,
                 16'($urandom_range(1, 500))));
      end
      default: send(hdr(1'b0, 1'b1, 1'b0, 1'b1, DIR_TO_SERVER, cli_seq, 16'd0));
    endcase
    // stray packet after the close
    if ($urandom_range(0, 2) == 0)
      send(hdr(1'b0, 1'b1, 1'b0, coin(), coin(), $urandom, pick_len()));
  endtask

  // Header with every field random; SYN kept rarer so other paths show up.
  task automatic send_noise();
    send(hdr($urandom_range(0, 3) == 0, coin(), coin(), coin(), coin(), $urandom,
             16'($urandom_range(0, 65535))));
    noise_headers++;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stall on segments of varying density, with free-flowing
  // stretches, and hold off for HOLD_CYCLES whenever the sender asks.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 1'b0;
    end else if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_taken != hold_asks) begin
      hold_taken = hold_asks;
      hold_left  = HOLD_CYCLES - 1;
      out_stall  = 1'b1;
    end else begin
      if (rx_seg_left <= 0) begin
        rx_mode     = rx_mode_t'($urandom_range(0, 3));
        rx_seg_left = $urandom_range(10, 80);
      end
      rx_seg_left--;
      case (rx_mode)
        RX_FREE:  out_stall = 1'b0;
        RX_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
        RX_HALF:  out_stall = coin();
        default:  out_stall = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: compare each taken result beat with the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: %s mismatch, got 0x%0h want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input tss_out_t got, input tss_out_t want);
    if (got.session_state_out != want.session_state_out)
      report_mismatch("session_state_out", 32'(got.session_state_out),
                      32'(want.session_state_out));
    if (got.first_payload_event != want.first_payload_event)
      report_mismatch("first_payload_event", 32'(got.first_payload_event),
                      32'(want.first_payload_event));
    if (got.direction_reversed_event != want.direction_reversed_event)
      report_mismatch("direction_reversed_event", 32'(got.direction_reversed_event),
                      32'(want.direction_reversed_event));
    if (got.payload_event != want.payload_event)
      report_mismatch("payload_event", 32'(got.payload_event),
                      32'(want.payload_event));
    if (got.fin_event != want.fin_event)
      report_mismatch("fin_event", 32'(got.fin_event), 32'(want.fin_event));
    if (got.rst_event != want.rst_event)
      report_mismatch("rst_event", 32'(got.rst_event), 32'(want.rst_event));
    if (got.write_offset != want.write_offset)
      report_mismatch("write_offset", got.write_offset, want.write_offset);
    if (got.window_length != want.window_length)
      report_mismatch("window_length", got.window_length, want.window_length);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (results_due.size() == 0) begin
        report_mismatch("unrequested result beat", out_beat.window_length, 32'h0);
      end else begin
        want_now = results_due.pop_front();
        check_result(out_beat, want_now);
      end
    end
  end

  // Watchdog: count cycles and give up well past the slowest correct run.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             results_due.size());
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence: reset, directed table, random sessions and noise, drain.
  // ---------------------------------------------------------------------
  initial begin
    trk_state    = CODE_HANDSHAKE;
    win_start[0] = '0;
    win_start[1] = '0;
    win_end[0]   = '0;
    win_end[1]   = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIRECTED_ROWS[i])
      offer_header(DIRECTED_ROWS[i].pkt, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    // let the pipeline empty completely before the random part
    drain_results();

    next_hold_mark = headers_sent;
    while (headers_sent < N_ROWS + RANDOM_HEADERS) begin
      if (headers_sent >= next_hold_mark) begin
        // long receiver hold while the sender keeps pushing: fills the queue
        hold_asks++;
        burst_left     = 80;
        next_hold_mark = headers_sent + HOLD_SPACING;
      end
      case ($urandom_range(0, 9))
        7, 8: repeat ($urandom_range(1, 6)) send_noise();
        9:    play_session(1'b1);
        default: play_session(1'b0);
      endcase
      if ($urandom_range(0, 11) == 0) drain_results();
    end

    drain_results();
    // linger so a stray extra result would still be caught
    repeat (10) @(negedge clk);

    $display("Covered %0d headers: %0d directed, %0d sessions plus %0d noise headers.",
             headers_sent, N_ROWS, sessions_run, noise_headers);
    $display("Checked %0d result beats through %0d long receiver holds.",
             results_seen, hold_asks);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
